// ----- rtl/core/rcl_pkg.sv -----
// Package for the range colormap lookup block.
// Holds the word types, mode and status codes and the chain flag struct.
// Depends on nothing; every other file of the block imports it.
package rcl_pkg;

  localparam logic [1:0] MODE_LOAD_ENTRY = 2'd0;
  localparam logic [1:0] MODE_LOAD_GAMMA = 2'd1;
  localparam logic [1:0] MODE_INTERP     = 2'd2;
  localparam logic [1:0] MODE_NEAREST    = 2'd3;

  localparam logic [2:0] ST_LOADED  = 3'd0;
  localparam logic [2:0] ST_HIT     = 3'd1;
  localparam logic [2:0] ST_BETWEEN = 3'd2;
  localparam logic [2:0] ST_BELOW   = 3'd3;
  localparam logic [2:0] ST_ABOVE   = 3'd4;
  localparam logic [2:0] ST_EMPTY   = 3'd5;
  localparam logic [2:0] ST_NONE    = 3'd6;

  typedef struct packed {
    logic [1:0]         mode;
    logic [3:0]         entry_index;
    logic signed [31:0] range_low;
    logic signed [31:0] range_high;
    logic [7:0]         red_in;
    logic [7:0]         green_in;
    logic [7:0]         blue_in;
    logic [7:0]         lut_address;
    logic [7:0]         lut_word;
    logic signed [31:0] sample;
  } in_word_t;

  typedef struct packed {
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic [2:0] status;
  } out_word_t;

  typedef struct packed {
    logic valid;
    logic hit;
    logic gap;
  } cell_flags_t;

endpackage

// ----- rtl/core/rcl_cell.sv -----
// One cell of the range chain: holds one table entry and checks the passing sample.
// Depends on rcl_pkg for the flag struct.
module rcl_cell #(
  parameter int W   = 32,
  parameter int NW  = 5,
  parameter int IDX = 0
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 wr_en,
  input  logic signed [W-1:0]  wr_low,
  input  logic signed [W-1:0]  wr_high,
  input  logic [23:0]          wr_color,
  input  logic signed [W-1:0]  nxt_low,
  input  logic [23:0]          nxt_color,
  input  rcl_pkg::cell_flags_t flags_in,
  input  logic signed [W-1:0]  z_in,
  input  logic [NW-1:0]        n_in,
  input  logic signed [W-1:0]  lo_in,
  input  logic signed [W-1:0]  hi_in,
  input  logic [23:0]          c1_in,
  input  logic [23:0]          c2_in,
  input  logic [W-1:0]         best_in,
  input  logic [23:0]          pick_in,
  input  logic [23:0]          hit_in,
  output rcl_pkg::cell_flags_t flags_out,
  output logic signed [W-1:0]  z_out,
  output logic [NW-1:0]        n_out,
  output logic signed [W-1:0]  lo_out,
  output logic signed [W-1:0]  hi_out,
  output logic [23:0]          c1_out,
  output logic [23:0]          c2_out,
  output logic [W-1:0]         best_out,
  output logic [23:0]          pick_out,
  output logic [23:0]          hit_out,
  output logic signed [W-1:0]  low,
  output logic signed [W-1:0]  high,
  output logic [23:0]          color
);
  import rcl_pkg::*;

  logic                active;
  logic                gap_ok;
  logic signed [W:0]   df1;
  logic signed [W:0]   df2;
  logic [W-1:0]        d1;
  logic [W-1:0]        d2;
  logic [W-1:0]        near_d;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      low   <= wr_low;
      high  <= wr_high;
      color <= wr_color;
    end
  end

  always_comb begin
    active = flags_in.valid && (IDX < int'(n_in));
    gap_ok = ((IDX + 1) < int'(n_in)) && (z_in >= high) && (z_in <= nxt_low);
    df1    = (W+1)'(z_in) - (W+1)'(low);
    df2    = (W+1)'(z_in) - (W+1)'(high);
    d1     = df1[W] ? W'(-df1) : W'(df1);
    d2     = df2[W] ? W'(-df2) : W'(df2);
    near_d = (d1 < d2) ? d1 : d2;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      flags_out <= '0;
    end else begin
      flags_out.valid <= flags_in.valid;
      flags_out.hit   <= flags_in.hit || (active && z_in >= low && z_in <= high);
      flags_out.gap   <= flags_in.gap || (active && gap_ok);
    end
  end

  always_ff @(posedge clk) begin
    z_out    <= z_in;
    n_out    <= n_in;
    lo_out   <= lo_in;
    hi_out   <= hi_in;
    c1_out   <= c1_in;
    c2_out   <= c2_in;
    best_out <= best_in;
    pick_out <= pick_in;
    hit_out  <= hit_in;
    if (active && !flags_in.hit && z_in >= low && z_in <= high) begin
      hit_out <= color;
    end
    if (active && !flags_in.gap && gap_ok) begin
      lo_out <= high;
      hi_out <= nxt_low;
      c1_out <= color;
      c2_out <= nxt_color;
    end
    if (active && near_d < best_in) begin
      best_out <= near_d;
      pick_out <= color;
    end
  end

endmodule

// ----- rtl/core/range_colormap_lookup.sv -----
// Top level of the range colormap lookup block.
// Depends on rcl_pkg and rcl_cell.
//
// Words enter on in_valid/in_ready/in_data and results leave on
// out_valid/out_ready/out_data, one result word for each input word.
// The entry count register is written through cfg_wr_en/cfg_wr_data.
// One word is in work at a time; in_ready is high only while the block
// is free, and a finished result waits in the output register while the
// next word is taken.
// Load words, and lookups that end below, above or on an empty table, go
// straight to the done state. Other lookups pass the sample down the
// chain of MAX_ENTRIES cells, one cell a cycle, then read the gamma table
// three times for a hit or nearest pick. A blend adds a multiply step, an
// 8-step divider and a step to take the quotient before those reads, and a
// lookup that no gap holds ends after the chain without the gamma reads.
// Reset clears control state, the entry count and the gamma valid bits, so
// the gamma table reads as identity until written. A stalled receiver holds
// the result; the block then finishes the next word and waits.
module range_colormap_lookup #(
  parameter int MAX_ENTRIES = 16,
  parameter int GAMMA_DEPTH = 256,
  parameter int VALUE_BITS  = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  rcl_pkg::in_word_t in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output rcl_pkg::out_word_t out_data,
  input  logic              cfg_wr_en,
  input  logic [4:0]        cfg_wr_data
);
  import rcl_pkg::*;

  localparam int W  = VALUE_BITS;
  localparam int NW = $clog2(MAX_ENTRIES + 1);
  localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int GW = $clog2(GAMMA_DEPTH);
  localparam int RW = W + 10;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_CHAIN = 6'b000010,
    S_MUL   = 6'b000100,
    S_DIV   = 6'b001000,
    S_GAM   = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  state_t state;
  logic [4:0] entry_count;

  cell_flags_t        tok_flags [0:MAX_ENTRIES];
  logic signed [W-1:0] tok_z    [0:MAX_ENTRIES];
  logic [NW-1:0]       tok_n    [0:MAX_ENTRIES];
  logic signed [W-1:0] tok_lo   [0:MAX_ENTRIES];
  logic signed [W-1:0] tok_hi   [0:MAX_ENTRIES];
  logic [23:0]         tok_c1   [0:MAX_ENTRIES];
  logic [23:0]         tok_c2   [0:MAX_ENTRIES];
  logic [W-1:0]        tok_best [0:MAX_ENTRIES];
  logic [23:0]         tok_pick [0:MAX_ENTRIES];
  logic [23:0]         tok_hit  [0:MAX_ENTRIES];
  logic signed [W-1:0] cell_low   [0:MAX_ENTRIES-1];
  logic signed [W-1:0] cell_high  [0:MAX_ENTRIES-1];
  logic [23:0]         cell_color [0:MAX_ENTRIES-1];

  logic                accept;
  logic                is_lookup;
  logic signed [W-1:0] z;
  logic signed [W-1:0] ra;
  logic signed [W-1:0] rb;
  logic [NW-1:0]       n_sat;
  logic [IW-1:0]       last_idx;
  logic                early;
  logic signed [W:0]   df0;
  logic [W-1:0]        best0;

  logic signed [W-1:0] zr;
  logic [1:0]          mode_r;
  logic [W-1:0]        den_r;
  logic [W-1:0]        d_r;
  logic [23:0]         c1_r;
  logic [23:0]         c2_r;
  logic [RW-1:0]       rem  [0:2];
  logic [RW-1:0]       dsh;
  logic [7:0]          quo  [0:2];
  logic [2:0]          dcnt;
  logic [23:0]         gcolor;
  logic [23:0]         res_color;
  logic [2:0]          res_status;
  logic [1:0]          gcnt;

  logic [7:0]          gmem [0:GAMMA_DEPTH-1];
  logic [GAMMA_DEPTH-1:0] gvalid;
  logic [GW-1:0]       g_ra;
  logic [GW-1:0]       g_ra_r;
  logic [7:0]          g_rd;
  logic                g_v_r;
  logic                gwe;

  assign in_ready  = (state == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign is_lookup = (in_data.mode == MODE_INTERP) || (in_data.mode == MODE_NEAREST);
  assign gwe       = accept && (in_data.mode == MODE_LOAD_GAMMA);

  always_comb begin
    z  = W'($signed(in_data.sample));
    ra = W'($signed(in_data.range_low));
    rb = W'($signed(in_data.range_high));
    if (int'(entry_count) > MAX_ENTRIES) begin
      n_sat = NW'(MAX_ENTRIES);
    end else begin
      n_sat = NW'(entry_count);
    end
    last_idx = IW'(n_sat - 1'b1);
    early    = (n_sat == '0) || (z <= cell_low[0]) || (z >= cell_high[last_idx]);
    df0      = (W+1)'(z) - (W+1)'(cell_low[0]);
    best0    = df0[W] ? W'(-df0) : W'(df0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
    end else if (cfg_wr_en) begin
      entry_count <= cfg_wr_data;
    end
  end

  assign tok_flags[0] = '{valid: accept && is_lookup && !early, hit: 1'b0, gap: 1'b0};
  assign tok_z[0]     = z;
  assign tok_n[0]     = n_sat;
  assign tok_lo[0]    = '0;
  assign tok_hi[0]    = '0;
  assign tok_c1[0]    = '0;
  assign tok_c2[0]    = '0;
  assign tok_best[0]  = best0;
  assign tok_pick[0]  = cell_color[0];
  assign tok_hit[0]   = '0;

  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    logic signed [W-1:0] nlow;
    logic [23:0]         ncolor;
    if (i < MAX_ENTRIES - 1) begin : g_mid
      assign nlow   = cell_low[i+1];
      assign ncolor = cell_color[i+1];
    end else begin : g_end
      assign nlow   = '0;
      assign ncolor = '0;
    end
    rcl_cell #(.W(W), .NW(NW), .IDX(i)) u_cell (
      .clk       (clk),
      .rst       (rst),
      .wr_en     (accept && (in_data.mode == MODE_LOAD_ENTRY) &&
                  (int'(in_data.entry_index) == i)),
      .wr_low    ((ra < rb) ? ra : rb),
      .wr_high   ((ra < rb) ? rb : ra),
      .wr_color  ({in_data.red_in, in_data.green_in, in_data.blue_in}),
      .nxt_low   (nlow),
      .nxt_color (ncolor),
      .flags_in  (tok_flags[i]),
      .z_in      (tok_z[i]),
      .n_in      (tok_n[i]),
      .lo_in     (tok_lo[i]),
      .hi_in     (tok_hi[i]),
      .c1_in     (tok_c1[i]),
      .c2_in     (tok_c2[i]),
      .best_in   (tok_best[i]),
      .pick_in   (tok_pick[i]),
      .hit_in    (tok_hit[i]),
      .flags_out (tok_flags[i+1]),
      .z_out     (tok_z[i+1]),
      .n_out     (tok_n[i+1]),
      .lo_out    (tok_lo[i+1]),
      .hi_out    (tok_hi[i+1]),
      .c1_out    (tok_c1[i+1]),
      .c2_out    (tok_c2[i+1]),
      .best_out  (tok_best[i+1]),
      .pick_out  (tok_pick[i+1]),
      .hit_out   (tok_hit[i+1]),
      .low       (cell_low[i]),
      .high      (cell_high[i]),
      .color     (cell_color[i])
    );
  end

  assign g_ra = gcolor[8*(2 - int'(gcnt)) +: 8];

  always_ff @(posedge clk) begin
    if (gwe) begin
      gmem[in_data.lut_address] <= in_data.lut_word;
    end
    g_rd   <= gmem[g_ra];
    g_ra_r <= g_ra;
    g_v_r  <= gvalid[g_ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gvalid <= '0;
    end else if (gwe) begin
      gvalid[in_data.lut_address] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      gcnt      <= '0;
      dcnt      <= '0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          gcnt <= '0;
          dcnt <= '0;
          if (accept) begin
            zr     <= z;
            mode_r <= in_data.mode;
            state  <= S_DONE;
            res_color  <= '0;
            res_status <= ST_LOADED;
            if (is_lookup) begin
              if (n_sat == '0) begin
                res_status <= ST_EMPTY;
              end else if (z <= cell_low[0]) begin
                res_color  <= cell_color[0];
                res_status <= ST_BELOW;
              end else if (z >= cell_high[last_idx]) begin
                res_color  <= cell_color[last_idx];
                res_status <= ST_ABOVE;
              end else begin
                state <= S_CHAIN;
              end
            end
          end
        end
        S_CHAIN: begin
          if (tok_flags[MAX_ENTRIES].valid) begin
            if (tok_flags[MAX_ENTRIES].hit) begin
              gcolor     <= tok_hit[MAX_ENTRIES];
              res_status <= ST_HIT;
              state      <= S_GAM;
            end else if (mode_r == MODE_NEAREST) begin
              gcolor     <= tok_pick[MAX_ENTRIES];
              res_status <= ST_BETWEEN;
              state      <= S_GAM;
            end else if (tok_flags[MAX_ENTRIES].gap) begin
              res_status <= ST_BETWEEN;
              den_r <= W'(tok_hi[MAX_ENTRIES] - tok_lo[MAX_ENTRIES]);
              d_r   <= W'(zr - tok_lo[MAX_ENTRIES]);
              c1_r  <= tok_c1[MAX_ENTRIES];
              c2_r  <= tok_c2[MAX_ENTRIES];
              if (tok_hi[MAX_ENTRIES] == tok_lo[MAX_ENTRIES]) begin
                gcolor <= tok_c1[MAX_ENTRIES];
                state  <= S_GAM;
              end else begin
                state <= S_MUL;
              end
            end else begin
              res_color  <= '0;
              res_status <= ST_NONE;
              state      <= S_DONE;
            end
          end
        end
        S_MUL: begin
          for (int k = 0; k < 3; k++) begin
            rem[k] <= ((RW'(c1_r[8*(2-k) +: 8]) * RW'(den_r - d_r) +
                        RW'(c2_r[8*(2-k) +: 8]) * RW'(d_r)) << 1) + RW'(den_r);
            quo[k] <= '0;
          end
          dsh   <= RW'(den_r) << 8;
          dcnt  <= '0;
          state <= S_DIV;
        end
        S_DIV: begin
          for (int k = 0; k < 3; k++) begin
            if (rem[k] >= dsh) begin
              rem[k] <= rem[k] - dsh;
              quo[k] <= {quo[k][6:0], 1'b1};
            end else begin
              quo[k] <= {quo[k][6:0], 1'b0};
            end
          end
          dsh  <= dsh >> 1;
          if (dcnt == 3'd7) begin
            state <= S_GAM;
          end else begin
            dcnt <= dcnt + 3'd1;
          end
        end
        S_GAM: begin
          if (gcnt == 2'd0 && dcnt == 3'd7 && mode_r == MODE_INTERP &&
              res_status == ST_BETWEEN && den_r != '0) begin
            gcolor <= {quo[0], quo[1], quo[2]};
            dcnt   <= '0;
          end else begin
            if (gcnt != 2'd0) begin
              res_color[8*(3 - int'(gcnt)) +: 8] <= g_v_r ? g_rd : 8'(g_ra_r);
            end
            gcnt <= gcnt + 2'd1;
            if (gcnt == 2'd3) begin
              state <= S_DONE;
            end
          end
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && (!out_valid || out_ready)) begin
      out_data.red_out   <= res_color[23:16];
      out_data.green_out <= res_color[15:8];
      out_data.blue_out  <= res_color[7:0];
      out_data.status    <= res_status;
    end
  end

endmodule

// ----- rtl/core/rcl_checker.sv -----
// Port checker for the range colormap lookup block, bound to the top level.
// Depends on rcl_pkg for the word types.
module rcl_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input rcl_pkg::out_word_t out_data
);
  import rcl_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("Stalled result word changed.");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("Input taken while a word is in work.");

  a_status: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.status != 3'd7)
    else $error("Result status has no meaning.");

  a_load_black: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status == ST_LOADED |->
      out_data.red_out == 8'd0 && out_data.green_out == 8'd0 &&
      out_data.blue_out == 8'd0)
    else $error("Load result word is not black.");

endmodule

bind range_colormap_lookup rcl_checker u_rcl_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
